[sv/infix_to_postfix_converter_core_defines.svh]
// Assertion macros for the infix to postfix converter.
// Compile with NO_ASSERTIONS defined to strip them.
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off during reset.
`define I2P_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("infix_to_postfix_converter_core: assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define I2P_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("infix_to_postfix_converter_core: assertion failed");

`else

`define I2P_ASSERT_NOW(label, ante, cons)
`define I2P_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/i2p_pkg.sv]
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);

  // Stack entry codes
  typedef enum logic [2:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } opc_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_UNMATCHED = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    CL_OTHER,
    CL_OPERAND,
    CL_OPEN,
    CL_CLOSE,
    CL_OPER
  } sym_class_t;

  typedef enum logic [1:0] {
    MODE_CLOSE,
    MODE_OPER,
    MODE_FLUSH
  } pop_mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TAIL,
    S_RD,
    S_EV,
    S_FIN
  } state_t;

  function automatic sym_class_t classify(logic [7:0] s);
    sym_class_t c;
    c = CL_OTHER;
    if (s inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]}) begin
      c = CL_OPERAND;
    end else if (s == 8'h28) begin
      c = CL_OPEN;
    end else if (s == 8'h29) begin
      c = CL_CLOSE;
    end else if (s inside {8'h2b, 8'h2d, 8'h2a, 8'h2f, 8'h5e}) begin
      c = CL_OPER;
    end
    return c;
  endfunction

  function automatic opc_t op_code(logic [7:0] s);
    opc_t c;
    case (s)
      8'h2b:   c = OP_ADD;
      8'h2d:   c = OP_SUB;
      8'h2a:   c = OP_MUL;
      8'h2f:   c = OP_DIV;
      8'h5e:   c = OP_POW;
      default: c = OP_OPEN;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] code_char(opc_t c);
    logic [7:0] ch;
    case (c)
      OP_OPEN: ch = 8'h28;
      OP_ADD:  ch = 8'h2b;
      OP_SUB:  ch = 8'h2d;
      OP_MUL:  ch = 8'h2a;
      OP_DIV:  ch = 8'h2f;
      OP_POW:  ch = 8'h5e;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] code_prec(opc_t c);
    logic [1:0] p;
    case (c)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

[sv/infix_to_postfix_converter_core.sv]
// Infix to postfix converter (shunting yard), one character word per accepted input.
// An operand's word passes the pending slot, then the output register, before out_valid.
// A new word is taken only in S_IDLE, once the last one is fully done (in_stall is high
//   until then); out_stall can hold the sequencer while a result waits to move out.
// Reset (rst_n low, synchronous): stack empty, sequencer idle, output empty.
//   Stack RAM contents are not cleared; only entries below the count are read.
`include "infix_to_postfix_converter_core_defines.svh"

module infix_to_postfix_converter_core
  import i2p_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_symbol,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       out_run_last,
  output logic [1:0] out_status
);

  // Sequencer state
  state_t            state_r, state_nxt;
  pop_mode_t         mode_r, mode_nxt;
  opc_t              oc_r, oc_nxt;
  logic              last_r, last_nxt;
  stat_t             status_r, status_nxt;

  // Stack bookkeeping: entry count and number of stacked open parentheses.
  // The open count tells at once whether a close parenthesis has a match,
  // so the word status is known before any result of the word leaves.
  logic [CNT_W-1:0]  stack_count_r, stack_count_nxt;
  logic [CNT_W-1:0]  open_cnt_r, open_cnt_nxt;

  // Stack RAM, one write and one registered read per cycle
  opc_t              stk_mem [STACK_DEPTH];
  opc_t              rd_q_r;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  opc_t              wr_code;

  // Pending result: held back one step, so run_last is known when it moves out
  logic              pend_v_r;
  logic [7:0]        pend_sym_r;
  logic              emit;
  logic [7:0]        emit_sym;
  logic              fin_move;
  logic              move;
  logic              can_emit;

  // Output register
  logic              out_v_r;
  logic [7:0]        out_sym_r;
  logic              out_last_r;
  stat_t             out_status_r;
  logic              out_free;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  assign out_free = !out_v_r || !out_stall;
  assign can_emit = !pend_v_r || out_free;
  assign move     = (emit && pend_v_r) || fin_move;

  // Always read the current top of stack; a pop or push changes the count,
  // and the sequencer passes through S_RD, which registers rd_q_r, before S_EV looks at it.
  assign rd_addr  = ADDR_W'(stack_count_r - CNT_ONE);

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = out_v_r;
  assign out_symbol   = out_sym_r;
  assign out_run_last = out_last_r;
  assign out_status   = out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      stack_count_r <= '0;
      open_cnt_r    <= '0;
      status_r      <= ST_OK;
      pend_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      stack_count_r <= stack_count_nxt;
      open_cnt_r    <= open_cnt_nxt;
      status_r      <= status_nxt;
      if (emit) begin
        pend_v_r <= 1'b1;
      end else if (fin_move) begin
        pend_v_r <= 1'b0;
      end
      if (out_free) begin
        out_v_r <= move;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    oc_r   <= oc_nxt;
    last_r <= last_nxt;
    if (emit) begin
      pend_sym_r <= emit_sym;
    end
    if (out_free && move) begin
      out_sym_r    <= pend_sym_r;
      out_last_r   <= fin_move;
      out_status_r <= status_r;
    end
  end

  // Stack RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stk_mem[wr_addr] <= wr_code;
    end
    rd_q_r <= stk_mem[rd_addr];
  end

  always_comb begin
    state_nxt       = state_r;
    mode_nxt        = mode_r;
    oc_nxt          = oc_r;
    last_nxt        = last_r;
    status_nxt      = status_r;
    stack_count_nxt = stack_count_r;
    open_cnt_nxt    = open_cnt_r;
    emit            = 1'b0;
    emit_sym        = 8'h00;
    fin_move        = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = stack_count_r[ADDR_W-1:0];
    wr_code         = OP_OPEN;

    case (state_r)
      S_IDLE: begin
        // Take a word; the pending slot is always empty here
        if (in_valid) begin
          last_nxt   = in_is_last;
          status_nxt = ST_OK;
          oc_nxt     = op_code(in_symbol);
          state_nxt  = S_TAIL;
          case (classify(in_symbol))
            CL_OPERAND: begin
              emit     = 1'b1;
              emit_sym = in_symbol;
            end
            CL_OPEN: begin
              if (stack_count_r == CNT_FULL) begin
                status_nxt = ST_FULL;
              end else begin
                wr_en           = 1'b1;
                wr_code         = OP_OPEN;
                stack_count_nxt = stack_count_r + CNT_ONE;
                open_cnt_nxt    = open_cnt_r + CNT_ONE;
              end
            end
            CL_CLOSE: begin
              mode_nxt  = MODE_CLOSE;
              state_nxt = S_RD;
              if (open_cnt_r == '0) begin
                status_nxt = ST_UNMATCHED;
              end
            end
            CL_OPER: begin
              mode_nxt  = MODE_OPER;
              state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end

      S_TAIL: begin
        // After the last word, flush the whole stack
        if (last_r) begin
          mode_nxt  = MODE_FLUSH;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_RD: begin
        if (stack_count_r == '0) begin
          case (mode_r)
            MODE_OPER: begin
              wr_en           = 1'b1;
              wr_code         = oc_r;
              stack_count_nxt = stack_count_r + CNT_ONE;
              state_nxt       = S_TAIL;
            end
            MODE_FLUSH: begin
              // Terminator
              if (can_emit) begin
                emit      = 1'b1;
                emit_sym  = 8'h00;
                state_nxt = S_FIN;
              end
            end
            default: state_nxt = S_TAIL;
          endcase
        end else begin
          state_nxt = S_EV;
        end
      end

      S_EV: begin
        case (mode_r)
          MODE_CLOSE: begin
            if (rd_q_r == OP_OPEN) begin
              // Drop the matching open parenthesis
              stack_count_nxt = stack_count_r - CNT_ONE;
              open_cnt_nxt    = open_cnt_r - CNT_ONE;
              state_nxt       = S_TAIL;
            end else if (can_emit) begin
              emit            = 1'b1;
              emit_sym        = code_char(rd_q_r);
              stack_count_nxt = stack_count_r - CNT_ONE;
              state_nxt       = S_RD;
            end
          end
          MODE_OPER: begin
            if (code_prec(rd_q_r) >= code_prec(oc_r)) begin
              if (can_emit) begin
                emit            = 1'b1;
                emit_sym        = code_char(rd_q_r);
                stack_count_nxt = stack_count_r - CNT_ONE;
                state_nxt       = S_RD;
              end
            end else if (stack_count_r == CNT_FULL) begin
              // Nothing popped and no room: drop the push
              status_nxt = ST_FULL;
              state_nxt  = S_TAIL;
            end else begin
              wr_en           = 1'b1;
              wr_code         = oc_r;
              stack_count_nxt = stack_count_r + CNT_ONE;
              state_nxt       = S_TAIL;
            end
          end
          default: begin
            // Flush pops everything, open parentheses included
            if (can_emit) begin
              emit            = 1'b1;
              emit_sym        = code_char(rd_q_r);
              stack_count_nxt = stack_count_r - CNT_ONE;
              if (rd_q_r == OP_OPEN) begin
                open_cnt_nxt = open_cnt_r - CNT_ONE;
              end
              state_nxt = S_RD;
            end
          end
        endcase
      end

      S_FIN: begin
        // Release the held result as the final one of this word; an error
        // with no result at all gets a lone terminator
        if (pend_v_r) begin
          if (out_free) begin
            fin_move  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (status_r != ST_OK) begin
          emit     = 1'b1;
          emit_sym = 8'h00;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  `I2P_ASSERT_NOW(a_count_bound, 1'b1, stack_count_r <= CNT_FULL)
  `I2P_ASSERT_NOW(a_open_le_count, 1'b1, open_cnt_r <= stack_count_r)
  `I2P_ASSERT_NOW(a_take_pend_empty, in_valid && !in_stall, !pend_v_r)
  `I2P_ASSERT_NEXT(a_fin_done, state_r == S_FIN && !pend_v_r && status_r == ST_OK,
                   state_r == S_IDLE)

endmodule
